>>> design/urlpd_pkg.sv
// Shared types, constants and the hex digit decoder for the URL percent decoder.
// Used by every module of the block; depends on nothing.
package urlpd_pkg;

  localparam logic [7:0] PERCENT_CHAR  = 8'h25;
  localparam logic [7:0] HEX_LC_OFFSET = 8'h57;
  localparam logic [7:0] HEX_UC_OFFSET = 8'h37;
  localparam logic [7:0] HEX_DG_OFFSET = 8'h30;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       decode_error;
    logic       escape_seen;
  } out_beat_t;

  typedef enum logic [1:0] {
    PH_TEXT  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef enum logic {
    CMD_SINGLE = 1'b0,  // one result beat
    CMD_PAIR   = 1'b1   // literal '%' beat, then the carried beat
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    out_beat_t beat;
  } cmd_t;

  typedef struct packed {
    logic empty;
    cmd_t head;
  } q_rd_t;

  // {valid, value}; valid is low for anything that is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h61:8'h66]}) begin
      d = c - HEX_LC_OFFSET;
      return {1'b1, d[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - HEX_UC_OFFSET;
      return {1'b1, d[3:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      d = c - HEX_DG_OFFSET;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

endpackage

>>> design/url_percent_decoder_core.sv
// URL percent decoder: one encoded byte per cycle in unless stalled, decoded out.
// Each result is queued, then loaded into the registered output stage.
// Throughput: one input beat per cycle while the queue is not full; a literal '%'
// pair at message end is split into two output beats.
// Reset (rst, synchronous): clears escape state, queue and output valid.
// Top level; depends on urlpd_pkg, urlpd_front, urlpd_queue, urlpd_back.
module url_percent_decoder_core #(
  parameter int QUEUE_DEPTH = urlpd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  urlpd_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output urlpd_pkg::out_beat_t out_data
);
  import urlpd_pkg::*;

  logic  q_push, q_pop, q_full;
  cmd_t  q_wdata;
  q_rd_t q_rd;

  urlpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  urlpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .rd    (q_rd)
  );

  urlpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rd        (q_rd),
    .out_stall (out_stall),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> design/urlpd_front.sv
// Front end: accepts input beats, runs the escape state machine and
// issues result commands into the queue. Depends on urlpd_pkg.
module urlpd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  urlpd_pkg::in_beat_t in_data,
  input  logic                q_full,
  output logic                in_stall,
  output logic                q_push,
  output urlpd_pkg::cmd_t     q_wdata
);
  import urlpd_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       error_latched, error_latched_next;
  logic       percent_found, percent_found_next;

  logic       accept;
  logic       emit;
  logic [4:0] hex;
  logic [7:0] b;
  logic       last;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && emit;
  assign b        = in_data.in_byte;
  assign last     = in_data.in_last;
  assign hex      = hex_value(b);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TEXT;
      high_nibble   <= 4'h0;
      error_latched <= 1'b0;
      percent_found <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      high_nibble   <= high_nibble_next;
      error_latched <= error_latched_next;
      percent_found <= percent_found_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    high_nibble_next   = high_nibble;
    error_latched_next = error_latched;
    percent_found_next = percent_found;
    emit               = 1'b0;
    q_wdata.kind              = CMD_SINGLE;
    q_wdata.beat.out_byte     = b;
    q_wdata.beat.out_last     = last;
    q_wdata.beat.decode_error = 1'b0;
    q_wdata.beat.escape_seen  = last && percent_found;

    if (!error_latched) begin
      case (phase)
        PH_PCT: begin
          if (last) begin
            emit         = 1'b1;
            q_wdata.kind = CMD_PAIR;
          end else begin
            if (hex[4]) high_nibble_next = hex[3:0];
            else        error_latched_next = 1'b1;
            phase_next = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          if (hex[4]) begin
            emit                  = 1'b1;
            q_wdata.beat.out_byte = {high_nibble, hex[3:0]};
          end else begin
            error_latched_next = 1'b1;
          end
          phase_next = PH_TEXT;
        end
        default: begin
          if (b == PERCENT_CHAR) begin
            percent_found_next = 1'b1;
            if (last) begin
              emit                     = 1'b1;
              q_wdata.beat.escape_seen = 1'b1;
            end else begin
              phase_next = PH_PCT;
            end
          end else begin
            emit = 1'b1;
          end
        end
      endcase
    end

    if (last) begin
      // replace whatever was built with one error beat
      if (error_latched_next) begin
        emit                      = 1'b1;
        q_wdata.kind              = CMD_SINGLE;
        q_wdata.beat.out_byte     = 8'h00;
        q_wdata.beat.decode_error = 1'b1;
        q_wdata.beat.escape_seen  = percent_found;
      end
      phase_next         = PH_TEXT;
      high_nibble_next   = 4'h0;
      error_latched_next = 1'b0;
      percent_found_next = 1'b0;
    end
  end

  a_err_needs_pct: assert property (@(posedge clk) disable iff (rst)
    error_latched |-> percent_found)
    else $error("error latched without a percent sign");

  a_digit_phase_pct: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PCT || phase == PH_DIGIT) |-> percent_found)
    else $error("escape phase without a percent sign");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (phase == PH_TEXT && !error_latched && !percent_found))
    else $error("state not cleared after final beat");

endmodule

>>> design/urlpd_queue.sv
// Command queue between front and back end; one push and one pop per cycle.
// Depends on urlpd_pkg.
module urlpd_queue #(
  parameter int DEPTH = urlpd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  urlpd_pkg::cmd_t     wdata,
  input  logic                pop,
  output logic                full,
  output urlpd_pkg::q_rd_t    rd
);
  import urlpd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == FULL_CNT);
  assign rd.empty = (count == '0);
  assign rd.head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !rd.empty)
    else $error("pop from empty queue");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance");

endmodule

>>> design/urlpd_back.sv
// Back end: drains queue commands into the output register, splitting
// a pair command into two beats. Depends on urlpd_pkg.
module urlpd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  urlpd_pkg::q_rd_t     rd,
  input  logic                 out_stall,
  output logic                 pop,
  output logic                 out_valid,
  output urlpd_pkg::out_beat_t out_data
);
  import urlpd_pkg::*;

  logic      load;
  logic      second, second_next;
  out_beat_t beat_next;

  assign load = !out_valid || !out_stall;

  always_comb begin
    beat_next   = rd.head.beat;
    second_next = second;
    pop         = 1'b0;
    if (load && !rd.empty) begin
      if (rd.head.kind == CMD_PAIR && !second) begin
        // literal '%' first, hold the entry for its partner beat
        beat_next.out_byte     = PERCENT_CHAR;
        beat_next.out_last     = 1'b0;
        beat_next.decode_error = 1'b0;
        beat_next.escape_seen  = 1'b0;
        second_next            = 1'b1;
      end else begin
        pop         = 1'b1;
        second_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      second <= second_next;
      if (load) out_valid <= !rd.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !rd.empty) out_data <= beat_next;
  end

  a_second_on_pair: assert property (@(posedge clk) disable iff (rst)
    second |-> (!rd.empty && rd.head.kind == CMD_PAIR))
    else $error("second half pending without a pair command");

  a_err_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.decode_error) |->
      (out_data.out_last && out_data.out_byte == 8'h00 && out_data.escape_seen))
    else $error("malformed error beat");

  a_pair_split: assert property (@(posedge clk) disable iff (rst)
    (load && !rd.empty && rd.head.kind == CMD_PAIR && !second) |=> second)
    else $error("pair command not split");

endmodule

>>> verif/tb_url_percent_decoder_core.sv
// Self-checking testbench for url_percent_decoder_core: directed and random URI
// messages under random idling and backpressure, checked against a local predictor.
// Depends on urlpd_pkg and url_percent_decoder_core.
module tb_url_percent_decoder_core;
  import urlpd_pkg::*;

  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_beat_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  // predictor state
  phase_t     esc_phase   = PH_TEXT;
  logic [3:0] held_nibble = 4'h0;
  bit         err_latched = 1'b0;
  bit         pct_found   = 1'b0;

  out_beat_t  expected_beats[$];
  logic [7:0] msg_bytes[$];

  int  mismatch_count = 0;
  int  items_sent     = 0;
  int  idle_cycles    = 0;
  bit  tx_idle_en     = 1'b0;
  bit  rx_idle_en     = 1'b0;
  int  hold_ticket    = 0;
  int  hold_served    = 0;
  int  hold_left      = 0;
  int  stall_left     = 0;

  url_percent_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // {is_digit, value}
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) t = c - HEX_DG_OFFSET;
    else if (c >= 8'h41 && c <= 8'h46) t = c - HEX_UC_OFFSET;
    else if (c >= 8'h61 && c <= 8'h66) t = c - HEX_LC_OFFSET;
    else return 5'h00;
    return {1'b1, t[3:0]};
  endfunction

  function automatic out_beat_t make_beat(input logic [7:0] b, input logic last,
                                          input logic err, input logic seen);
    out_beat_t r;
    r.out_byte     = b;
    r.out_last     = last;
    r.decode_error = last & err;
    r.escape_seen  = last & seen;
    return r;
  endfunction

  task automatic predict_decode(input in_beat_t b);
    logic [4:0] hv;
    hv = 5'h00;
    if (err_latched) begin
      // drop bytes until the message ends
    end else if (esc_phase == PH_PCT) begin
      if (b.in_last) begin
        expected_beats.push_back(make_beat(PERCENT_CHAR, 1'b0, 1'b0, 1'b0));
        expected_beats.push_back(make_beat(b.in_byte, 1'b1, 1'b0, pct_found));
      end else begin
        hv = digit_value(b.in_byte);
        if (!hv[4]) err_latched = 1'b1;
        else held_nibble = hv[3:0];
        esc_phase = PH_DIGIT;
      end
    end else if (esc_phase == PH_DIGIT) begin
      hv = digit_value(b.in_byte);
      if (!hv[4]) err_latched = 1'b1;
      else expected_beats.push_back(make_beat({held_nibble, hv[3:0]}, b.in_last, 1'b0,
                                              pct_found));
      esc_phase = PH_TEXT;
    end else if (b.in_byte == PERCENT_CHAR) begin
      pct_found = 1'b1;
      if (b.in_last) expected_beats.push_back(make_beat(b.in_byte, 1'b1, 1'b0, 1'b1));
      else esc_phase = PH_PCT;
    end else begin
      expected_beats.push_back(make_beat(b.in_byte, b.in_last, 1'b0, pct_found));
    end
    if (b.in_last) begin
      // an error ends the message with one flagged beat in place of its last byte
      if (err_latched) expected_beats.push_back(make_beat(8'h00, 1'b1, 1'b1, pct_found));
      esc_phase   = PH_TEXT;
      held_nibble = 4'h0;
      err_latched = 1'b0;
      pct_found   = 1'b0;
    end
  endtask

  task automatic send_beat(input logic [7:0] b, input logic last);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.in_byte <= b;
    in_data.in_last <= last;
    do @(posedge clk); while (in_stall);
    predict_decode({b, last});
    items_sent++;
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg_bytes.size(); i++)
      send_beat(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
    send_msg();
  endtask

  function automatic logic [7:0] rand_hex_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'h30 + 8'(k);
    if (k < 16) return 8'h61 + 8'(k - 10);
    return 8'h41 + 8'(k - 16);
  endfunction

  function automatic logic [7:0] rand_bad_digit();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (digit_value(c) != 5'h00) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic send_random_message(input bit well_formed);
    int len;
    int k;
    logic [7:0] c;
    len = $urandom_range(1, 12);
    while (msg_bytes.size() < len) begin
      k = $urandom_range(0, 9);
      if (well_formed) begin
        if (k < 3) begin
          msg_bytes.push_back(PERCENT_CHAR);
          msg_bytes.push_back(rand_hex_char());
          msg_bytes.push_back(rand_hex_char());
        end else if (k == 3) begin
          msg_bytes.push_back(PERCENT_CHAR);
        end else begin
          c = 8'($urandom_range(0, 255));
          msg_bytes.push_back(c == PERCENT_CHAR ? 8'h7e : c);
        end
      end else begin
        if (k < 4) msg_bytes.push_back(8'($urandom_range(0, 255)));
        else if (k < 6) msg_bytes.push_back(PERCENT_CHAR);
        else if (k == 6) begin
          msg_bytes.push_back(PERCENT_CHAR);
          msg_bytes.push_back(rand_bad_digit());
        end else if (k == 7) begin
          msg_bytes.push_back(PERCENT_CHAR);
          msg_bytes.push_back(rand_hex_char());
          msg_bytes.push_back(rand_bad_digit());
        end else msg_bytes.push_back(rand_hex_char());
      end
    end
    send_msg();
  endtask

  task automatic send_random_items(input int n, input int noise_pct);
    int start;
    start = items_sent;
    while (items_sent - start < n)
      send_random_message($urandom_range(1, 100) > noise_pct);
  endtask

  // lower valid and wait until every expected beat has come back
  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  task automatic test_plain_bytes();
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hff);
    send_msg();
  endtask

  task automatic test_good_escapes();
    send_text("%41z");
    send_text("%fF");
  endtask

  task automatic test_short_percent();
    send_text("%");
    msg_bytes.push_back(PERCENT_CHAR);
    msg_bytes.push_back(8'h00);
    send_msg();
  endtask

  task automatic test_bad_digits();
    send_text("a%G1b");
    msg_bytes.push_back(PERCENT_CHAR);
    msg_bytes.push_back(8'h31);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'h71);
    send_msg();
    send_text("%%x");
  endtask

  task automatic test_random_traffic();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_random_items(1200, 30);
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_ticket++;
    send_random_items(100, 20);
  endtask

  task automatic test_sender_pause();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_random_items(25, 30);
    drain_outputs();
    send_random_items(25, 30);
  endtask

  task automatic test_full_rate_tail();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random_items(500, 30);
  endtask

  // receiver: random stall bursts, plus one long hold on request
  always @(posedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_beat_t exp_beat;
    bit        have_exp;
    if (!rst && out_valid && !out_stall) begin
      exp_beat = '0;
      have_exp = expected_beats.size() != 0;
      if (have_exp) exp_beat = expected_beats.pop_front();
      if (!have_exp || out_data.out_byte !== exp_beat.out_byte ||
          out_data.out_last !== exp_beat.out_last ||
          out_data.decode_error !== exp_beat.decode_error ||
          out_data.escape_seen !== exp_beat.escape_seen) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("mismatch: byte/last/err/seen expected%s %h/%b/%b/%b, got %h/%b/%b/%b",
                   have_exp ? "" : " (none)", exp_beat.out_byte, exp_beat.out_last,
                   exp_beat.decode_error, exp_beat.escape_seen, out_data.out_byte,
                   out_data.out_last, out_data.decode_error, out_data.escape_seen);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", idle_cycles);
      $display("url_percent_decoder_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_plain_bytes();
    test_good_escapes();
    test_short_percent();
    test_bad_digits();
    test_random_traffic();
    test_backpressure();
    test_sender_pause();
    test_full_rate_tail();
    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("url_percent_decoder_core test passed");
    end else begin
      $display("url_percent_decoder_core test failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/urlpd_pkg.sv
design/urlpd_front.sv
design/urlpd_queue.sv
design/urlpd_back.sv
design/url_percent_decoder_core.sv
verif/tb_url_percent_decoder_core.sv
